// ===== rtl/core/ber_tlv_header_parser_defines.svh =====
// assertion macros used by the checker of the header parser
`ifndef BER_TLV_HEADER_PARSER_DEFINES_SVH
`define BER_TLV_HEADER_PARSER_DEFINES_SVH

// clocked assertion, switched off while reset is held
`define BTLV_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds across reset
`define BTLV_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/btlv_pkg.sv =====
`timescale 1ns / 1ps
package btlv_pkg;

  // width of the bytes-left count that is honoured
  localparam int unsigned LEN_BITS = 24;
  localparam logic [23:0] LEFT_MASK = 24'((64'd1 << LEN_BITS) - 64'd1);

  // parser phases
  localparam logic [1:0] PH_IDLE      = 2'd0;
  localparam logic [1:0] PH_TAG       = 2'd1;
  localparam logic [1:0] PH_LEN_FIRST = 2'd2;
  localparam logic [1:0] PH_LEN_BYTES = 2'd3;

  localparam logic [4:0] TAG_HIGH_FORM = 5'h1f;
  localparam logic [7:0] LEN_INDEFINITE = 8'h80;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        start_req;
    logic [23:0] bytes_left;
  } item_t;

  typedef struct packed {
    logic        constructed;
    logic [31:0] tag_number;
    logic [23:0] content_length;
    logic [7:0]  header_length;
    logic        parse_error;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } res_beat_t;

endpackage

// ===== rtl/core/btlv_if.sv =====
`timescale 1ns / 1ps
// input byte channel
interface btlv_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        start_req;
  logic [23:0] bytes_left;

  modport source (output valid, output data_byte, output start_req, output bytes_left,
                  input ready);
  modport sink (input valid, input data_byte, input start_req, input bytes_left,
                output ready);
endinterface

// result channel
interface btlv_out_if;
  logic        valid;
  logic        ready;
  logic        constructed;
  logic [31:0] tag_number;
  logic [23:0] content_length;
  logic [7:0]  header_length;
  logic        parse_error;

  modport source (output valid, output constructed, output tag_number,
                  output content_length, output header_length, output parse_error,
                  input ready);
  modport sink (input valid, input constructed, input tag_number,
                input content_length, input header_length, input parse_error,
                output ready);
endinterface

// ===== rtl/core/btlv_decoder.sv =====
`timescale 1ns / 1ps
module btlv_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  btlv_pkg::item_t    item,
  output btlv_pkg::res_beat_t beat
);

  logic [1:0]  phase_r,   phase_nxt;
  logic [31:0] tag_r,     tag_nxt;
  logic        cons_r,    cons_nxt;
  logic [31:0] len_acc_r, len_acc_nxt;
  logic [6:0]  due_r,     due_nxt;
  logic [7:0]  hcount_r,  hcount_nxt;

  logic [23:0] left;
  logic        last;
  logic [23:0] remaining;
  logic [7:0]  hcount_inc;
  logic [7:0]  b;
  logic        do_err;
  logic        do_done;
  logic        len_bad;
  logic [23:0] len_clamped;

  always_comb begin
    b          = item.data_byte;
    left       = item.bytes_left & btlv_pkg::LEFT_MASK;
    last       = (left <= 24'd1);
    remaining  = last ? 24'd0 : left - 24'd1;
    hcount_inc = (hcount_r == 8'hff) ? hcount_r : hcount_r + 8'd1;

    phase_nxt   = phase_r;
    tag_nxt     = tag_r;
    cons_nxt    = cons_r;
    len_acc_nxt = len_acc_r;
    due_nxt     = due_r;
    hcount_nxt  = hcount_r;
    do_err      = 1'b0;
    do_done     = 1'b0;

    if (item.start_req) begin
      if (left < 24'd2) begin
        do_err = 1'b1;
      end else begin
        cons_nxt    = b[5];
        hcount_nxt  = 8'd1;
        len_acc_nxt = '0;
        due_nxt     = '0;
        if (b[4:0] == btlv_pkg::TAG_HIGH_FORM) begin
          tag_nxt   = '0;
          phase_nxt = btlv_pkg::PH_TAG;
        end else begin
          tag_nxt   = {27'd0, b[4:0]};
          phase_nxt = btlv_pkg::PH_LEN_FIRST;
        end
      end
    end else begin
      unique case (phase_r)
        btlv_pkg::PH_TAG: begin
          hcount_nxt = hcount_inc;
          tag_nxt    = {tag_r[24:0], b[6:0]};
          if (!b[7]) phase_nxt = btlv_pkg::PH_LEN_FIRST;
          if (last) do_err = 1'b1;
        end
        btlv_pkg::PH_LEN_FIRST: begin
          hcount_nxt = hcount_inc;
          if (b == btlv_pkg::LEN_INDEFINITE) begin
            do_err = 1'b1;
          end else if (b[7]) begin
            len_acc_nxt = '0;
            due_nxt     = b[6:0];
            phase_nxt   = btlv_pkg::PH_LEN_BYTES;
            if (last) do_err = 1'b1;
          end else begin
            len_acc_nxt = {24'd0, b};
            do_done     = 1'b1;
          end
        end
        btlv_pkg::PH_LEN_BYTES: begin
          hcount_nxt  = hcount_inc;
          len_acc_nxt = {len_acc_r[23:0], b};
          due_nxt     = (due_r != 7'd0) ? due_r - 7'd1 : 7'd0;
          if (due_nxt == 7'd0) do_done = 1'b1;
          else if (last) do_err = 1'b1;
        end
        default: begin
        end
      endcase
    end

    // long form with the top bit set is refused
    len_bad     = do_done && len_acc_nxt[31];
    len_clamped = (len_acc_nxt > {8'd0, remaining}) ? remaining : len_acc_nxt[23:0];

    if (do_err || do_done) phase_nxt = btlv_pkg::PH_IDLE;

    beat.valid = step && (do_err || do_done);
    if (do_err || len_bad) begin
      beat.res = '0;
      beat.res.parse_error = 1'b1;
    end else begin
      beat.res.constructed    = cons_nxt;
      beat.res.tag_number     = tag_nxt;
      beat.res.content_length = len_clamped;
      beat.res.header_length  = hcount_nxt;
      beat.res.parse_error    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= btlv_pkg::PH_IDLE;
      tag_r     <= '0;
      cons_r    <= 1'b0;
      len_acc_r <= '0;
      due_r     <= '0;
      hcount_r  <= '0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      tag_r     <= tag_nxt;
      cons_r    <= cons_nxt;
      len_acc_r <= len_acc_nxt;
      due_r     <= due_nxt;
      hcount_r  <= hcount_nxt;
    end
  end

endmodule

// ===== rtl/core/btlv_out_reg.sv =====
`timescale 1ns / 1ps
module btlv_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  btlv_pkg::res_beat_t load,
  output logic                free,
  btlv_out_if.source          out_ch
);

  logic              valid_r, valid_nxt;
  btlv_pkg::result_t res_r;

  assign free      = !valid_r || out_ch.ready;
  assign valid_nxt = load.valid || (valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load.valid) begin
      res_r <= load.res;
    end
  end

  assign out_ch.valid          = valid_r;
  assign out_ch.constructed    = res_r.constructed;
  assign out_ch.tag_number     = res_r.tag_number;
  assign out_ch.content_length = res_r.content_length;
  assign out_ch.header_length  = res_r.header_length;
  assign out_ch.parse_error    = res_r.parse_error;

endmodule

// ===== rtl/core/ber_tlv_header_parser.sv =====
`timescale 1ns / 1ps
// a header result passes the input register, then the result register, after its last byte
// throughput: one byte per cycle while results drain, set by the single-pass byte decoder
// a waiting result stalls input only once the input register is also full
// reset: synchronous, active low; parser idles, no result beat pending
module ber_tlv_header_parser (
  input  logic       clk,
  input  logic       rst_n,
  btlv_in_if.sink    in_ch,
  btlv_out_if.source out_ch
);

  // input register, one byte deep
  logic            s1_valid_r, s1_valid_nxt;
  btlv_pkg::item_t s1_item_r;

  // decoder to result register
  btlv_pkg::res_beat_t dec_beat;
  logic                out_free;
  logic                s1_go;
  logic                in_take;

  // the byte moves on as soon as the result register can take whatever it makes
  assign s1_go        = s1_valid_r && out_free;
  assign in_ch.ready  = !s1_valid_r || s1_go;
  assign in_take      = in_ch.valid && in_ch.ready;
  assign s1_valid_nxt = in_take || (s1_valid_r && !s1_go);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.data_byte  <= in_ch.data_byte;
      s1_item_r.start_req  <= in_ch.start_req;
      s1_item_r.bytes_left <= in_ch.bytes_left;
    end
  end

  // header state machine and accumulators, stepped once per byte
  btlv_decoder u_decoder (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (s1_go),
    .item  (s1_item_r),
    .beat  (dec_beat)
  );

  // result register, one beat deep
  btlv_out_reg u_out_reg (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (dec_beat),
    .free   (out_free),
    .out_ch (out_ch)
  );

endmodule

// ===== rtl/core/btlv_checker.sv =====
`timescale 1ns / 1ps
`include "ber_tlv_header_parser_defines.svh"
module btlv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_constructed,
  input logic [31:0] out_tag_number,
  input logic [23:0] out_content_length,
  input logic [7:0]  out_header_length,
  input logic        out_parse_error
);

  // error beats carry nothing else
  `BTLV_ASSERT(a_err_zero, clk, rst_n, out_valid && out_parse_error |-> !out_constructed && out_tag_number == 32'd0 && out_content_length == 24'd0 && out_header_length == 8'd0, "error beat with non-zero fields")

  // a good header has identifier and length bytes
  `BTLV_ASSERT(a_hdr_len, clk, rst_n, out_valid && !out_parse_error |-> out_header_length >= 8'd2, "header shorter than two bytes")

  // stalled beat holds
  `BTLV_ASSERT(a_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_tag_number) && $stable(out_content_length) && $stable(out_parse_error), "stalled result beat changed")

  // nothing pending straight after reset
  `BTLV_ASSERT_RST(a_rst, clk, !rst_n |=> !out_valid, "result beat after reset")

endmodule

bind ber_tlv_header_parser btlv_checker u_btlv_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_constructed    (out_ch.constructed),
  .out_tag_number     (out_ch.tag_number),
  .out_content_length (out_ch.content_length),
  .out_header_length  (out_ch.header_length),
  .out_parse_error    (out_ch.parse_error)
);

// ===== dv/tb_ber_tlv_header_parser.sv =====
`timescale 1ns / 1ps
module tb_ber_tlv_header_parser;

  // generous ceiling: several times the slowest legal run
  localparam int CYCLE_LIMIT = 400000;
  // directed tests send about 850 bytes, the random test tops it up
  localparam int RANDOM_BYTES = 250;

  logic clk;
  logic rst_n;

  btlv_in_if  in_ch ();
  btlv_out_if out_ch ();

  ber_tlv_header_parser uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 20 ns period
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // header decoder mirror, advanced on every accepted input beat
  logic [1:0]  hdr_phase;
  logic [31:0] tag_acc;
  logic        cons_flag;
  logic [31:0] len_acc;
  logic [6:0]  len_due;
  logic [7:0]  hdr_count;

  btlv_pkg::result_t expected_headers[$];
  logic [7:0]        hdr_bytes[$];

  int fail_count;
  int cycles;
  int bytes_sent;
  int results_seen;
  int parser_errors;

  // idling controls shared between the stimulus and the result side
  bit tx_idle_on;
  bit rx_idle_on;
  int rx_hold;
  int rx_stall;

  // mostly back to back, some short gaps, the odd long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // works out what one accepted byte does to the header being decoded
  task automatic decode_header_byte(input logic [7:0] data, input logic start,
                                    input logic [23:0] left);
    logic              last;
    logic [23:0]       remaining;
    logic              fin;
    logic              err;
    btlv_pkg::result_t res;
    last = (left <= 24'd1);
    remaining = last ? 24'd0 : left - 24'd1;
    fin = 1'b0;
    err = 1'b0;
    if (start) begin
      if (left < 24'd2) begin
        // short buffer: no room for even a two-byte header
        err = 1'b1;
      end else begin
        // restart drops any partial header without a result
        cons_flag = data[5];
        hdr_count = 8'd1;
        len_acc = '0;
        len_due = '0;
        if (data[4:0] == btlv_pkg::TAG_HIGH_FORM) begin
          tag_acc = '0;
          hdr_phase = btlv_pkg::PH_TAG;
        end else begin
          tag_acc = {27'd0, data[4:0]};
          hdr_phase = btlv_pkg::PH_LEN_FIRST;
        end
      end
    end else begin
      case (hdr_phase)
        btlv_pkg::PH_TAG: begin
          if (hdr_count != 8'hff) hdr_count++;
          // base-128 digits, low 32 bits kept
          tag_acc = {tag_acc[24:0], data[6:0]};
          if (!data[7]) hdr_phase = btlv_pkg::PH_LEN_FIRST;
          if (last) err = 1'b1;
        end
        btlv_pkg::PH_LEN_FIRST: begin
          if (hdr_count != 8'hff) hdr_count++;
          if (data == btlv_pkg::LEN_INDEFINITE) begin
            err = 1'b1;
          end else if (data[7]) begin
            len_acc = '0;
            len_due = data[6:0];
            hdr_phase = btlv_pkg::PH_LEN_BYTES;
            if (last) err = 1'b1;
          end else begin
            len_acc = {24'd0, data};
            fin = 1'b1;
          end
        end
        btlv_pkg::PH_LEN_BYTES: begin
          if (hdr_count != 8'hff) hdr_count++;
          // extra length bytes shift the top ones out
          len_acc = {len_acc[23:0], data};
          if (len_due != 0) len_due--;
          if (len_due == 0) fin = 1'b1;
          else if (last) err = 1'b1;
        end
        default: begin
          // idle byte without start: ignored
        end
      endcase
    end
    if (fin && len_acc[31]) err = 1'b1;
    if (err) begin
      res = '0;
      res.parse_error = 1'b1;
      expected_headers.push_back(res);
      hdr_phase = btlv_pkg::PH_IDLE;
    end else if (fin) begin
      res.constructed = cons_flag;
      res.tag_number = tag_acc;
      res.content_length = (len_acc > {8'd0, remaining}) ? remaining : len_acc[23:0];
      res.header_length = hdr_count;
      res.parse_error = 1'b0;
      expected_headers.push_back(res);
      hdr_phase = btlv_pkg::PH_IDLE;
    end
  endtask

  // both channels are sampled at the rising edge: input beats feed the
  // decoder mirror, result beats are checked against the oldest expectation
  always @(posedge clk) begin
    btlv_pkg::result_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        decode_header_byte(in_ch.data_byte, in_ch.start_req, in_ch.bytes_left);
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_headers.size() == 0) begin
          $error("result beat with no header pending");
          fail_count++;
        end else begin
          want = expected_headers.pop_front();
          if (want.parse_error) parser_errors++;
          if (out_ch.constructed !== want.constructed) begin
            $error("constructed expected %0h got %0h", want.constructed, out_ch.constructed);
            fail_count++;
          end
          if (out_ch.tag_number !== want.tag_number) begin
            $error("tag_number expected %0h got %0h", want.tag_number, out_ch.tag_number);
            fail_count++;
          end
          if (out_ch.content_length !== want.content_length) begin
            $error("content_length expected %0h got %0h",
                   want.content_length, out_ch.content_length);
            fail_count++;
          end
          if (out_ch.header_length !== want.header_length) begin
            $error("header_length expected %0h got %0h",
                   want.header_length, out_ch.header_length);
            fail_count++;
          end
          if (out_ch.parse_error !== want.parse_error) begin
            $error("parse_error expected %0h got %0h", want.parse_error, out_ch.parse_error);
            fail_count++;
          end
        end
      end
    end
  end

  // result side: a requested hold-off wins, otherwise random stalls
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_ch.ready <= 1'b0;
      rx_hold--;
    end else if (rx_stall > 0) begin
      out_ch.ready <= 1'b0;
      rx_stall--;
    end else begin
      out_ch.ready <= 1'b1;
      if (rx_idle_on && $urandom_range(0, 3) == 0) rx_stall = pick_gap();
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // one input beat, with an optional gap before it; valid stays high
  // into the next beat when no gap follows
  task automatic send_byte(input logic [7:0] data, input logic start,
                           input logic [23:0] left);
    int gap;
    gap = tx_idle_on ? pick_gap() : 0;
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= data;
    in_ch.start_req <= start;
    in_ch.bytes_left <= left;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  // walks hdr_bytes as the head of a buffer of left0 bytes, stopping
  // where the buffer ends or after cut bytes
  task automatic send_buffer(input logic [23:0] left0, input int cut);
    for (int i = 0; i < hdr_bytes.size() && i < cut && i < left0; i++)
      send_byte(hdr_bytes[i], i == 0, left0 - 24'(i));
  endtask

  // drop valid and let every outstanding result drain
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_headers.size() != 0) @(posedge clk);
  endtask

  task automatic test_short_buffer();
    // start byte with one byte left, then with a zero count
    send_byte(8'h30, 1'b1, 24'd1);
    send_byte(8'h02, 1'b1, 24'd0);
    // stray byte while idle: no result
    send_byte(8'hff, 1'b0, 24'd10);
    wait_drained();
  endtask

  task automatic test_short_forms();
    hdr_bytes = '{8'h30, 8'h05};
    send_buffer(24'd10, 2);
    // length clamped to what is left after the header
    hdr_bytes = '{8'hde, 8'h7f};
    send_buffer(24'd5, 2);
    hdr_bytes = '{8'h00, 8'h00};
    send_buffer(24'd2, 2);
    wait_drained();
  endtask

  task automatic test_high_tag();
    hdr_bytes = '{8'h3f, 8'h81, 8'h00, 8'h03};
    send_buffer(24'd20, 4);
    // leading zero digit
    hdr_bytes = '{8'hdf, 8'h80, 8'h05, 8'h01};
    send_buffer(24'hffffff, 4);
    wait_drained();
  endtask

  task automatic test_long_length();
    hdr_bytes = '{8'h02, 8'h82, 8'h01, 8'h00};
    send_buffer(24'hffffff, 4);
    // bit 31 set: error
    hdr_bytes = '{8'h04, 8'h84, 8'h80, 8'h00, 8'h00, 8'h00};
    send_buffer(24'd100, 6);
    // five bytes: the bit 31 byte shifts out again
    hdr_bytes = '{8'h04, 8'h85, 8'h80, 8'h00, 8'h00, 8'h00, 8'h10};
    send_buffer(24'd100, 7);
    // indefinite length
    hdr_bytes = '{8'h30, btlv_pkg::LEN_INDEFINITE};
    send_buffer(24'd50, 2);
    wait_drained();
  endtask

  task automatic test_truncation_and_restart();
    // buffer ends inside the tag, then inside long-form length bytes
    hdr_bytes = '{8'h1f, 8'h81, 8'h01};
    send_buffer(24'd2, 3);
    hdr_bytes = '{8'h04, 8'h82, 8'h01, 8'h00};
    send_buffer(24'd3, 4);
    // zero count on the final length byte acts like one
    send_byte(8'h04, 1'b1, 24'd3);
    send_byte(8'h05, 1'b0, 24'd0);
    // new start mid-header drops the partial one
    send_byte(8'h1f, 1'b1, 24'd10);
    send_byte(8'h02, 1'b1, 24'd9);
    send_byte(8'h01, 1'b0, 24'd8);
    wait_drained();
  endtask

  task automatic test_header_saturation();
    // 263-byte header: count pins at 255
    hdr_bytes = {};
    hdr_bytes.push_back(8'h1f);
    repeat (259) hdr_bytes.push_back({1'b1, 7'($urandom)});
    hdr_bytes.push_back(8'h05);
    hdr_bytes.push_back(8'h81);
    hdr_bytes.push_back(8'h40);
    send_buffer(24'd1000, hdr_bytes.size());
    // exactly 255 bytes
    hdr_bytes = {};
    hdr_bytes.push_back(8'h3f);
    repeat (247) hdr_bytes.push_back({1'b1, 7'($urandom)});
    hdr_bytes.push_back(8'h11);
    hdr_bytes.push_back(8'h85);
    repeat (5) hdr_bytes.push_back(8'h00);
    send_buffer(24'd600, hdr_bytes.size());
    // 127 length bytes, only the last four survive
    hdr_bytes = '{8'h3f, 8'h01, 8'hff};
    repeat (123) hdr_bytes.push_back(8'($urandom));
    hdr_bytes.push_back(8'h00);
    hdr_bytes.push_back(8'h00);
    hdr_bytes.push_back(8'h01);
    hdr_bytes.push_back(8'h00);
    send_buffer(24'd1000, hdr_bytes.size());
    wait_drained();
  endtask

  // random well-formed header with some malformed length forms mixed in
  task automatic build_random_header();
    logic [7:0] ident;
    int n;
    int r;
    hdr_bytes = {};
    ident = 8'($urandom);
    if ($urandom_range(0, 1)) ident[4:0] = btlv_pkg::TAG_HIGH_FORM;
    hdr_bytes.push_back(ident);
    if (ident[4:0] == btlv_pkg::TAG_HIGH_FORM) begin
      n = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 3) : $urandom_range(4, 6);
      for (int k = 0; k < n; k++)
        hdr_bytes.push_back({k < n - 1, 7'($urandom)});
    end
    r = $urandom_range(0, 99);
    if (r < 40) begin
      hdr_bytes.push_back(8'($urandom_range(0, 127)));
    end else if (r < 70) begin
      n = $urandom_range(1, 3);
      hdr_bytes.push_back(8'h80 | 8'(n));
      repeat (n) hdr_bytes.push_back(8'($urandom));
    end else if (r < 82) begin
      // four bytes, top bit set half the time
      hdr_bytes.push_back(8'h84);
      repeat (4) hdr_bytes.push_back(8'($urandom));
    end else if (r < 90) begin
      n = $urandom_range(5, 8);
      hdr_bytes.push_back(8'h80 | 8'(n));
      repeat (n) hdr_bytes.push_back(8'($urandom));
    end else if (r < 95) begin
      hdr_bytes.push_back(btlv_pkg::LEN_INDEFINITE);
    end else begin
      n = $urandom_range(1, 2);
      hdr_bytes.push_back(8'h80 | 8'(n));
      repeat (n) hdr_bytes.push_back(8'($urandom_range(0, 3)));
    end
  endtask

  task automatic test_random_headers();
    int start_count;
    int hdr_idx;
    int r;
    int cut;
    logic [23:0] left0;
    start_count = bytes_sent;
    hdr_idx = 0;
    while (bytes_sent - start_count < RANDOM_BYTES) begin
      // switch idling on and off in stretches
      if (hdr_idx % 40 == 0) begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
      end
      hdr_idx++;
      build_random_header();
      r = $urandom_range(0, 99);
      if (r < 70) left0 = 24'(hdr_bytes.size() + $urandom_range(0, 300));
      else if (r < 80) left0 = 24'($urandom_range(1, hdr_bytes.size()));
      else if (r < 95) left0 = 24'($urandom_range(1, 24'hffffff));
      else left0 = 24'hffffff;
      // occasionally cut the header short so the next start restarts it
      cut = hdr_bytes.size();
      if (cut > 1 && $urandom_range(0, 19) == 0) cut = $urandom_range(1, cut - 1);
      // occasional stray byte, ignored unless a header is open
      if ($urandom_range(0, 19) == 0)
        send_byte(8'($urandom), 1'b0, 24'($urandom_range(0, 24'hffffff)));
      send_buffer(left0, cut);
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    // result side held off while short headers keep coming
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    @(posedge clk);
    rx_hold = 150;
    repeat (60) begin
      hdr_bytes = '{8'($urandom_range(0, 30)), 8'($urandom_range(0, 127))};
      send_buffer(24'($urandom_range(2, 200)), 2);
    end
    // sender waits for the full drain before going on
    wait_drained();
    repeat (20) begin
      hdr_bytes = '{8'h30, 8'($urandom_range(0, 127))};
      send_buffer(24'd300, 2);
    end
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.start_req = 1'b0;
    in_ch.bytes_left = '0;
    out_ch.ready = 1'b0;
    hdr_phase = btlv_pkg::PH_IDLE;
    tag_acc = '0;
    cons_flag = 1'b0;
    len_acc = '0;
    len_due = '0;
    hdr_count = '0;
    fail_count = 0;
    cycles = 0;
    bytes_sent = 0;
    results_seen = 0;
    parser_errors = 0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    rx_hold = 0;
    rx_stall = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_short_buffer();
    test_short_forms();
    test_high_tag();
    test_long_length();
    test_truncation_and_restart();
    test_header_saturation();
    test_backpressure();
    test_random_headers();

    // let every result drain, then idle before the summary
    wait_drained();
    repeat (10) @(posedge clk);

    $display("sent %0d header bytes, checked %0d result beats (%0d parse errors)",
             bytes_sent, results_seen, parser_errors);
    $display("short/high tags, short/long/indefinite lengths, truncation, restart");
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/btlv_pkg.sv
rtl/core/btlv_if.sv
rtl/core/btlv_decoder.sv
rtl/core/btlv_out_reg.sv
rtl/core/ber_tlv_header_parser.sv
rtl/core/btlv_checker.sv
dv/tb_ber_tlv_header_parser.sv
